[rtl/sra_pkg.sv]
// Package for the section address translator: sizes, codes and the item token
// that travels down the row of section cells. No dependencies.
package sra_pkg;

  localparam int MAX_SECTIONS = 16;
  localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  localparam int ADDR_W       = 32;
  localparam int OFFSET_W     = ADDR_W + 1;
  localparam int ENTRY_W      = 4;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam int S_TDATA_W    = 136;
  localparam int M_TDATA_W    = 40;

  localparam logic [ADDR_W-1:0] ALIGN_MASK_RST = ADDR_W'(4095);

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_XLATE = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGN = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_reg_e;

  // One translate item on its way through the cells.
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   rva;
    logic                hit;
    logic [OFFSET_W-1:0] bias;
    logic [IDX_W-1:0]    entry;
  } sra_tok_t;

endpackage

[rtl/section_rva_to_file_offset.sv]
// Top level of the section address translator: stream ports, configuration
// registers, the row of sra_cell instances and the result register. Uses sra_pkg.
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o  load or translate item
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i  translate result
//  cfg       in         cfg_we_i                       alignment, section count
//
// A load item writes its cell when it is accepted and gives no result.
// A translate item walks the row one cell a cycle: its result is registered
// after the entry stages, every cell of the row and the result register.
// One translate item is in the block at a time: s_axis_tready_o is low from its
// acceptance until its result is taken. Reset empties the row and the result
// register; table entries read as undefined until loaded.
module section_rva_to_file_offset
  import sra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // entry_index[3:0], section_start[35:4], section_size[67:36],
  // section_file_position[99:68], relative_address[131:100], zero fill above
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // func[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // file_offset[32:0], hit_entry[36:33], zero fill above
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  // miss[0]
  output logic                  m_axis_tuser_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [ADDR_W-1:0]   align_mask_q;
  logic [COUNT_W-1:0]  count_q;
  logic                busy_q;
  logic                out_valid_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [ENTRY_W-1:0]  entry_q;
  logic                miss_q;

  logic                pre_vld_q;
  logic [ADDR_W-1:0]   pre_rva_q;
  logic                tok0_vld_q;
  logic [ADDR_W-1:0]   tok0_rva_q;

  logic                s_fire;
  logic                m_fire;
  logic                load_fire;
  logic                xlate_fire;

  logic [3:0]          in_entry;
  logic [ADDR_W-1:0]   in_start;
  logic [ADDR_W-1:0]   in_size;
  logic [ADDR_W-1:0]   in_fpos;
  logic [ADDR_W-1:0]   in_rva;

  sra_tok_t            tok [MAX_SECTIONS+1];
  logic [MAX_SECTIONS:0] tok_vld;

  assign in_entry = s_axis_tdata_i[3:0];
  assign in_start = s_axis_tdata_i[35:4];
  assign in_size  = s_axis_tdata_i[67:36];
  assign in_fpos  = s_axis_tdata_i[99:68];
  assign in_rva   = s_axis_tdata_i[131:100];

  assign s_axis_tready_o = !busy_q;
  assign s_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire     = m_axis_tvalid_o && m_axis_tready_i;
  assign load_fire  = s_fire && (func_e'(s_axis_tuser_i) == FUNC_LOAD);
  assign xlate_fire = s_fire && (func_e'(s_axis_tuser_i) == FUNC_XLATE);

  // Configuration registers; the alignment is kept as its mask (alignment - 1).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_mask_q <= ALIGN_MASK_RST;
      count_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ALIGN: align_mask_q <= cfg_wdata_i - CFG_DATA_W'(1);
        CFG_COUNT: count_q      <= cfg_wdata_i[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Two entry stages give the cells time to refresh their aligned ends
  // after a load or an alignment write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= 1'b0;
      tok0_vld_q <= 1'b0;
    end else begin
      pre_vld_q  <= xlate_fire;
      tok0_vld_q <= pre_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xlate_fire) begin
      pre_rva_q <= in_rva;
    end
    tok0_rva_q <= pre_rva_q;
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = tok0_vld_q;
    tok[0].rva   = tok0_rva_q;
  end

  for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
    logic in_use;
    logic wr_en;

    assign in_use = (32'(count_q) > 32'(g));
    assign wr_en  = load_fire && (32'(in_entry) == 32'(g));

    sra_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (IDX_W'(g)),
      .in_use_i     (in_use),
      .align_mask_i (align_mask_q),
      .wr_en_i      (wr_en),
      .wr_start_i   (in_start),
      .wr_size_i    (in_size),
      .wr_fpos_i    (in_fpos),
      .tok_i        (tok[g]),
      .tok_o        (tok[g+1])
    );
  end

  for (genvar g = 0; g <= MAX_SECTIONS; g++) begin : g_vld
    assign tok_vld[g] = tok[g].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (xlate_fire) begin
        busy_q <= 1'b1;
      end else if (m_fire) begin
        busy_q <= 1'b0;
      end
      if (tok[MAX_SECTIONS].valid) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[MAX_SECTIONS].valid) begin
      if (tok[MAX_SECTIONS].hit) begin
        offset_q <= {1'b0, tok[MAX_SECTIONS].rva} + tok[MAX_SECTIONS].bias;
        entry_q  <= ENTRY_W'(tok[MAX_SECTIONS].entry);
        miss_q   <= 1'b0;
      end else begin
        offset_q <= '0;
        entry_q  <= '0;
        miss_q   <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, entry_q, offset_q};
  assign m_axis_tuser_o  = miss_q;

`ifndef NO_ASSERTIONS
  // Only one translate item may be anywhere in the entry stages and cell row.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_vld, pre_vld_q}))
    else $error("more than one translate item in the cell row");

  // A pending result belongs to the item that keeps the input closed.
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> busy_q)
    else $error("result shown while the block is not busy");

  // A miss carries a zero offset and entry.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("miss result with nonzero offset or entry");

  // A translate item reaches the first cell after passing both entry stages.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xlate_fire |=> ##1 tok0_vld_q)
    else $error("translate item lost before the first cell");
`endif

endmodule

[rtl/sra_cell.sv]
// One section cell: holds a table entry, checks the passing item against it
// and hands the item on to the next cell. Depends on sra_pkg.
module sra_cell
  import sra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    cell_idx_i,
  input  logic                in_use_i,
  input  logic [ADDR_W-1:0]   align_mask_i,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_start_i,
  input  logic [ADDR_W-1:0]   wr_size_i,
  input  logic [ADDR_W-1:0]   wr_fpos_i,
  input  sra_tok_t            tok_i,
  output sra_tok_t            tok_o
);

  logic [ADDR_W-1:0]   start_q;
  logic [ADDR_W-1:0]   size_q;
  logic [OFFSET_W-1:0] bias_q;
  logic [ADDR_W-1:0]   asz_q;
  logic [ADDR_W-1:0]   end_q;

  logic                vld_q;
  sra_tok_t            tok_d;
  sra_tok_t            pay_q;
  logic                match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      start_q <= wr_start_i;
      size_q  <= wr_size_i;
      // File position minus start, modulo 2^33, so the output stage needs one add.
      bias_q  <= {1'b0, wr_fpos_i} - {1'b0, wr_start_i};
    end
    // The aligned end is refreshed every cycle, through asz_q and then end_q,
    // so that loads and alignment writes reach it.
    asz_q <= (size_q + align_mask_i) & ~align_mask_i;
    end_q <= asz_q + start_q;
  end

  assign match = in_use_i && (start_q <= tok_i.rva) && (end_q > tok_i.rva);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit   = 1'b1;
      tok_d.bias  = bias_q;
      tok_d.entry = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= tok_d;
  end

  always_comb begin
    tok_o       = pay_q;
    tok_o.valid = vld_q;
  end

endmodule
